### sv/rms_level_dbfs_meter_assert.svh
// Assertion macros shared by the level meter checker.
`ifndef RMS_LEVEL_DBFS_METER_ASSERT_SVH
`define RMS_LEVEL_DBFS_METER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rlm_pkg.sv
// Widths and constants of the RMS level meter.
package rlm_pkg;

  // Frame length bound; the tally saturates here
  localparam int MAX_FRAME_SAMPLES = 1024;

  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 16;
  localparam int TALLY_W   = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int ENERGY_W  = 30 + TALLY_W;
  localparam int NORM_W    = ENERGY_W;
  localparam int E_W       = $clog2(NORM_W);
  localparam int MANT_W    = 31;
  localparam int FRAC_BITS = 20;
  localparam int FCNT_W    = $clog2(FRAC_BITS);
  localparam int LOG_W     = E_W + FRAC_BITS;
  localparam int D_W       = LOG_W + 2;
  localparam int MAG_W     = D_W - 1;
  localparam int K_W       = 18;
  localparam int SCL_W     = MAG_W + K_W;
  localparam int ROUND_SHIFT = 28;
  localparam int Q_W       = SCL_W + 1 - ROUND_SHIFT;
  localparam int MUL_W     = 32;

  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_FRAME_SAMPLES);
  localparam logic [E_W-1:0]     E_TOP     = E_W'(NORM_W - 1);
  localparam logic [FCNT_W-1:0]  FRAC_TOP  = FCNT_W'(FRAC_BITS - 1);
  // 30.0 in Q20: full-scale square is 2^30
  localparam logic [D_W-1:0]     LOG_OFFSET = D_W'(30 << FRAC_BITS);
  // 10*log10(2) in Q16
  localparam logic [K_W-1:0]     TEN_LOG10_2_Q16 = K_W'(197283);
  localparam logic [SCL_W:0]     ROUND_BIAS = (SCL_W + 1)'(1 << (ROUND_SHIFT - 1));
  localparam logic [Q_W-1:0]     FLOOR_MAG  = Q_W'(24576);
  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = LEVEL_W'(-24576);

endpackage

### sv/rlm_if.sv
// Sample and level channel interfaces of the RMS level meter.
interface rlm_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rlm_pkg::SAMPLE_W-1:0]   sample;
  logic                                  last;

  modport source(output valid, output sample, output last, input ready);
  modport sink(input valid, input sample, input last, output ready);
endinterface

interface rlm_level_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rlm_pkg::LEVEL_W-1:0]    level_db_q8;

  modport source(output valid, output level_db_q8, input ready);
  modport sink(input valid, input level_db_q8, output ready);
endinterface

### sv/rlm_out_stage.sv
// Output register that holds a level result until the receiver takes it.
module rlm_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic signed [rlm_pkg::LEVEL_W-1:0]  push_level,
  output logic                                space,
  rlm_level_if.source                         levels
);

  logic                               full;
  logic signed [rlm_pkg::LEVEL_W-1:0] held;

  // Room for a new result when empty or when the held one leaves now
  assign space = !full || levels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (levels.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_level;
    end
  end

  assign levels.valid       = full;
  assign levels.level_db_q8 = held;

endmodule

### sv/rms_level_dbfs_meter.sv
// Frame RMS level meter in dBFS with one shared multiplier under a sequencer.
//
// samples: one signed 16-bit PCM sample per request, last marks frame end.
// levels : one Q8 dBFS level per frame, in [-96 dB, 0 dB].
// Each sample is registered in the request cycle, then in ST_SQUARE the
// shared multiplier squares it into the 41-bit energy sum. samples.ready is
// low in between. Samples past 1024 in a frame are dropped from the sums.
// On the last sample the same multiplier runs log2 of the energy and of the
// tally: a one-bit-per-cycle normalizing shift and 20 squaring steps each,
// then one scaling multiply. A silent frame goes from ST_LOAD straight to
// ST_DONE with the -96 dB floor; others run the log and scaling states
// first. The next sample is taken once ST_DONE has pushed the result.
// If the receiver stalls, a result waits in the output register while the
// next frame accumulates; a second result waits in the sequencer until the
// register frees, and samples.ready stays low meanwhile.
// Reset (rst, synchronous) clears the sums, the sequencer and the output
// register; no clearing pass is needed.
module rms_level_dbfs_meter (
  input  logic         clk,
  input  logic         rst,
  rlm_sample_if.sink   samples,
  rlm_level_if.source  levels
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQUARE = 4'd1;
  localparam logic [3:0] ST_LOAD   = 4'd2;
  localparam logic [3:0] ST_NORM   = 4'd3;
  localparam logic [3:0] ST_FRAC   = 4'd4;
  localparam logic [3:0] ST_DIFF   = 4'd5;
  localparam logic [3:0] ST_SCALE  = 4'd6;
  localparam logic [3:0] ST_ROUND  = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]                               state;
  logic signed [rlm_pkg::SAMPLE_W-1:0]      sample_q;
  logic                                     last_q;
  logic [rlm_pkg::ENERGY_W-1:0]             energy_sum;
  logic [rlm_pkg::TALLY_W-1:0]              sample_tally;
  logic [rlm_pkg::NORM_W-1:0]               norm;
  logic [rlm_pkg::E_W-1:0]                  e_cnt;
  logic [rlm_pkg::MANT_W-1:0]               mant;
  logic [rlm_pkg::FCNT_W-1:0]               frac_cnt;
  logic [rlm_pkg::LOG_W-1:0]                log_acc;
  logic [rlm_pkg::LOG_W-1:0]                log_energy;
  logic                                     tally_pass;
  logic                                     neg;
  logic [rlm_pkg::MAG_W-1:0]                mag;
  logic [rlm_pkg::SCL_W-1:0]                scaled;
  logic signed [rlm_pkg::LEVEL_W-1:0]       level;

  logic [rlm_pkg::SAMPLE_W-1:0]             sample_mag;
  logic [rlm_pkg::MUL_W-1:0]                mul_a;
  logic [rlm_pkg::MUL_W-1:0]                mul_b;
  logic [2*rlm_pkg::MUL_W-1:0]              mul_p;
  logic [rlm_pkg::MANT_W:0]                 sq_hi;
  logic                                     frac_bit;
  logic [rlm_pkg::MANT_W-1:0]               mant_sq;
  logic [rlm_pkg::LOG_W-1:0]                log_shift;
  logic [rlm_pkg::D_W-1:0]                  diff;
  logic [rlm_pkg::D_W-1:0]                  diff_neg;
  logic [rlm_pkg::SCL_W:0]                  round_sum;
  logic [rlm_pkg::Q_W-1:0]                  q;
  logic                                     out_space;
  logic                                     push;

  assign samples.ready = (state == ST_IDLE);

  // Magnitude of the sample; -32768 maps to 32768 unsigned
  assign sample_mag = sample_q[rlm_pkg::SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;

  // Shared multiplier operand select
  always_comb begin
    case (state)
      ST_SQUARE: begin
        mul_a = {{(rlm_pkg::MUL_W-rlm_pkg::SAMPLE_W){1'b0}}, sample_mag};
        mul_b = {{(rlm_pkg::MUL_W-rlm_pkg::SAMPLE_W){1'b0}}, sample_mag};
      end
      ST_FRAC: begin
        mul_a = {{(rlm_pkg::MUL_W-rlm_pkg::MANT_W){1'b0}}, mant};
        mul_b = {{(rlm_pkg::MUL_W-rlm_pkg::MANT_W){1'b0}}, mant};
      end
      ST_SCALE: begin
        mul_a = {{(rlm_pkg::MUL_W-rlm_pkg::MAG_W){1'b0}}, mag};
        mul_b = {{(rlm_pkg::MUL_W-rlm_pkg::K_W){1'b0}}, rlm_pkg::TEN_LOG10_2_Q16};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One log2 fraction bit: square the Q30 mantissa, renormalize on overflow
  assign sq_hi     = mul_p[2*rlm_pkg::MANT_W-1:rlm_pkg::MANT_W-1];
  assign frac_bit  = sq_hi[rlm_pkg::MANT_W];
  assign mant_sq   = frac_bit ? sq_hi[rlm_pkg::MANT_W:1] : sq_hi[rlm_pkg::MANT_W-1:0];
  assign log_shift = {log_acc[rlm_pkg::LOG_W-2:0], frac_bit};

  // log2(energy) - log2(tally) - 30, signed Q20
  assign diff     = {2'b00, log_energy} - {2'b00, log_acc} - rlm_pkg::LOG_OFFSET;
  assign diff_neg = '0 - diff;

  // Round half up on the magnitude, Q36 down to Q8
  assign round_sum = {1'b0, scaled} + rlm_pkg::ROUND_BIAS;
  assign q         = round_sum[rlm_pkg::SCL_W:rlm_pkg::ROUND_SHIFT];

  assign push = (state == ST_DONE) && out_space;

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      energy_sum   <= '0;
      sample_tally <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (sample_tally < rlm_pkg::TALLY_MAX) begin
            energy_sum <= energy_sum +
              {{(rlm_pkg::ENERGY_W-2*rlm_pkg::SAMPLE_W+1){1'b0}},
               mul_p[2*rlm_pkg::SAMPLE_W-2:0]};
            sample_tally <= sample_tally + 1'b1;
          end
          state <= last_q ? ST_LOAD : ST_IDLE;
        end
        ST_LOAD: begin
          state <= (energy_sum == '0) ? ST_DONE : ST_NORM;
        end
        ST_NORM: begin
          if (norm[rlm_pkg::NORM_W-1]) begin
            state <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          if (frac_cnt == '0) begin
            state <= tally_pass ? ST_DIFF : ST_NORM;
          end
        end
        ST_DIFF: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_space) begin
            energy_sum   <= '0;
            sample_tally <= '0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sample_q <= samples.sample;
        last_q   <= samples.last;
      end
      ST_LOAD: begin
        norm       <= energy_sum;
        e_cnt      <= rlm_pkg::E_TOP;
        tally_pass <= 1'b0;
        level      <= rlm_pkg::LEVEL_FLOOR;
      end
      ST_NORM: begin
        // Shift one place a cycle until the leading one reaches the top
        if (norm[rlm_pkg::NORM_W-1]) begin
          mant     <= norm[rlm_pkg::NORM_W-1 -: rlm_pkg::MANT_W];
          log_acc  <= {{rlm_pkg::FRAC_BITS{1'b0}}, e_cnt};
          frac_cnt <= rlm_pkg::FRAC_TOP;
        end else begin
          norm  <= {norm[rlm_pkg::NORM_W-2:0], 1'b0};
          e_cnt <= e_cnt - 1'b1;
        end
      end
      ST_FRAC: begin
        mant     <= mant_sq;
        log_acc  <= log_shift;
        frac_cnt <= frac_cnt - 1'b1;
        if (frac_cnt == '0 && !tally_pass) begin
          log_energy <= log_shift;
          norm       <= {{(rlm_pkg::NORM_W-rlm_pkg::TALLY_W){1'b0}}, sample_tally};
          e_cnt      <= rlm_pkg::E_TOP;
          tally_pass <= 1'b1;
        end
      end
      ST_DIFF: begin
        neg <= diff[rlm_pkg::D_W-1];
        mag <= diff[rlm_pkg::D_W-1] ? diff_neg[rlm_pkg::MAG_W-1:0]
                                    : diff[rlm_pkg::MAG_W-1:0];
      end
      ST_SCALE: begin
        scaled <= mul_p[rlm_pkg::SCL_W-1:0];
      end
      ST_ROUND: begin
        // Clamp to [-96 dB, 0 dB]
        if (!neg) begin
          level <= '0;
        end else if (q > rlm_pkg::FLOOR_MAG) begin
          level <= rlm_pkg::LEVEL_FLOOR;
        end else begin
          level <= '0 - q[rlm_pkg::LEVEL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  rlm_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_level (level),
    .space      (out_space),
    .levels     (levels)
  );

endmodule

### sv/rms_level_dbfs_meter_checker.sv
// Port-level checker for the RMS level meter, bound to the top level.
`include "rms_level_dbfs_meter_assert.svh"

module rms_level_dbfs_meter_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               samples_valid,
  input logic                               samples_ready,
  input logic                               levels_valid,
  input logic                               levels_ready,
  input logic signed [rlm_pkg::LEVEL_W-1:0] levels_data
);

  // Results stay within the clamp range
  `RLM_ASSERT_SAME(a_level_range, levels_valid, (levels_data <= 0) && (levels_data >= rlm_pkg::LEVEL_FLOOR), "level outside -96..0 dB")

  // A taken sample keeps the block busy for its accumulate cycle
  `RLM_ASSERT_NEXT(a_busy_after_request, samples_valid && samples_ready, !samples_ready, "sample taken back to back")

  // A stalled result stays offered and unchanged
  `RLM_ASSERT_NEXT(a_level_hold, levels_valid && !levels_ready, levels_valid, "level dropped while stalled")
  `RLM_ASSERT_NEXT(a_level_stable, levels_valid && !levels_ready, $stable(levels_data), "level changed while stalled")

endmodule

bind rms_level_dbfs_meter rms_level_dbfs_meter_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .samples_valid (samples.valid),
  .samples_ready (samples.ready),
  .levels_valid  (levels.valid),
  .levels_ready  (levels.ready),
  .levels_data   (levels.level_db_q8)
);
